// ----- src/bsa_pkg.sv -----
// Shared types and constants of the banker's safety allocator.
package bsa_pkg;

    localparam int MAX_PROCESSES_DEF = 16;
    localparam int MAX_RESOURCES_DEF = 8;
    localparam int AMOUNT_BITS_DEF   = 8;

    localparam int NUM_PROC_BITS = 5;
    localparam int NUM_RES_BITS  = 4;
    localparam int CFG_DATA_BITS = 5;

    typedef enum logic [1:0] {
        CMD_AVAIL = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_MAX   = 2'd2,
        CMD_REQ   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_GRANT  = 2'd0,
        ST_CLAIM  = 2'd1,
        ST_SHORT  = 2'd2,
        ST_UNSAFE = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        CFG_NUM_PROCESSES = 1'b0,
        CFG_NUM_RESOURCES = 1'b1
    } cfg_index_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [3:0] process;
        logic [2:0] resource;
        logic [7:0] amount;
        logic       last;
    } item_t;

    typedef struct packed {
        status_t    status;
        logic [3:0] process_served;
    } verdict_t;

endpackage

// ----- src/bankers_safety_allocator.sv -----
// Banker's algorithm allocator: tables, request check and iterative safety scan.
//
//  Channel   Handshake                Payload                  Notes
//  -------   ----------------------   ----------------------   -----------------------------
//  cmd       cmd_valid / cmd_ready    cmd_item  (item_t)       loads and request elements
//  verdict   verdict_valid / _ready   verdict_item (verdict_t) one per final request element
//  cfg       cfg_valid / cfg_ready    cfg_index, cfg_data      num_processes, num_resources
//
// A load item or a non-final request element is taken directly in the idle state.
// A final request element goes through the claim and availability check over the
// requester's row, then a safety scan of up to n passes, each visiting up to n
// processes with a need test per resource and a work update for each finishing
// process, then a commit of the grant to the tables and a verdict into the output
// register (n processes and m resources in use). The pace is set by the single
// read port pair of the allocation and maximum tables, each entry read and then
// evaluated through one shared need, compare and saturating add unit.
// Reset clears the control state, the available vector and the request buffer;
// the allocation and maximum tables hold no reset value and must be loaded.
// cmd_ready is low while a verdict is being worked out; loads are taken while
// an earlier verdict still waits in the output register.
module bankers_safety_allocator #(
    parameter int MAX_PROCESSES = bsa_pkg::MAX_PROCESSES_DEF,
    parameter int MAX_RESOURCES = bsa_pkg::MAX_RESOURCES_DEF,
    parameter int AMOUNT_BITS   = bsa_pkg::AMOUNT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  bsa_pkg::item_t                    cmd_item,
    output logic                              verdict_valid,
    input  logic                              verdict_ready,
    output bsa_pkg::verdict_t                 verdict_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  bsa_pkg::cfg_index_t               cfg_index,
    input  logic [bsa_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    localparam int PIDX      = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int RIDX      = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int PCNT      = $clog2(MAX_PROCESSES + 1);
    localparam int RCNT      = $clog2(MAX_RESOURCES + 1);
    localparam int DEPTH     = MAX_PROCESSES * MAX_RESOURCES;
    localparam int ADDR      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WORK_BITS = AMOUNT_BITS + 4;
    localparam int CMP_BITS  = WORK_BITS + 1;

    typedef logic [AMOUNT_BITS-1:0] amt_t;
    typedef logic [WORK_BITS-1:0]   work_t;

    // One-hot sequencer states.
    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_CHK_RD  = 11'b000_0000_0010,
        S_CHK_EV  = 11'b000_0000_0100,
        S_PSEL    = 11'b000_0000_1000,
        S_SCAN_RD = 11'b000_0001_0000,
        S_SCAN_EV = 11'b000_0010_0000,
        S_ADD_RD  = 11'b000_0100_0000,
        S_ADD_EV  = 11'b000_1000_0000,
        S_COM_RD  = 11'b001_0000_0000,
        S_COM_WR  = 11'b010_0000_0000,
        S_OUT     = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic [bsa_pkg::NUM_PROC_BITS-1:0] num_proc_reg, num_proc_next;
    logic [bsa_pkg::NUM_RES_BITS-1:0]  num_res_reg, num_res_next;
    amt_t  avail_reg [MAX_RESOURCES];
    amt_t  avail_next [MAX_RESOURCES];
    amt_t  pend_reg [MAX_RESOURCES];
    amt_t  pend_next [MAX_RESOURCES];
    work_t work_reg [MAX_RESOURCES];
    work_t work_next [MAX_RESOURCES];
    logic [MAX_PROCESSES-1:0] fin_reg, fin_next;
    logic [PCNT-1:0] sp_reg, sp_next;
    logic [PCNT-1:0] done_reg, done_next;
    logic [RCNT-1:0] sr_reg, sr_next;
    logic            prog_reg, prog_next;
    logic            exceed_reg, exceed_next;
    logic            short_reg, short_next;
    logic [3:0]      req_proc_reg, req_proc_next;
    bsa_pkg::status_t  status_reg, status_next;
    logic              out_valid_reg, out_valid_next;
    bsa_pkg::verdict_t out_reg, out_next;

    amt_t alloc_mem [DEPTH];
    amt_t max_mem [DEPTH];
    amt_t alloc_rd_reg;
    amt_t max_rd_reg;

    logic [PCNT-1:0] rows;
    logic [RCNT-1:0] cols;
    logic [PIDX-1:0] pidx, req_row, row_sel, load_row;
    logic [RIDX-1:0] ridx, load_col;
    logic [ADDR-1:0] rd_addr, load_addr, wr_addr;
    logic            accept, rin, pin, in_chk, in_com, use_pend;
    logic            sr_last, sp_last;
    amt_t            amt_in, pend_cur, avail_cur, alloc_eff, alloc_wdata;
    work_t           work_cur, work_sat;
    logic [WORK_BITS:0]        sum_w;
    logic signed [CMP_BITS-1:0] need_s, work_s, pend_s;
    logic            chk_exceed, chk_short;
    logic            alloc_we, max_we;
    state_t          adv_state;
    logic [PCNT-1:0] adv_sp;
    logic            adv_prog, adv_clear, adv_unsafe;

    // Register values outside their range are clamped to 1 .. table size.
    always_comb
    begin
        if (num_proc_reg == '0)
            rows = PCNT'(1);
        else if (int'(num_proc_reg) > MAX_PROCESSES)
            rows = PCNT'(MAX_PROCESSES);
        else
            rows = PCNT'(num_proc_reg);
        if (num_res_reg == '0)
            cols = RCNT'(1);
        else if (int'(num_res_reg) > MAX_RESOURCES)
            cols = RCNT'(MAX_RESOURCES);
        else
            cols = RCNT'(num_res_reg);
    end

    assign accept    = cmd_valid && cmd_ready;
    assign cmd_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // Input item decode. Rows and columns outside the tables are ignored.
    assign amt_in    = amt_t'(cmd_item.amount);
    assign rin       = int'(cmd_item.resource) < MAX_RESOURCES;
    assign pin       = int'(cmd_item.process) < MAX_PROCESSES;
    assign load_row  = PIDX'(cmd_item.process);
    assign load_col  = RIDX'(cmd_item.resource);
    assign load_addr = ADDR'(int'(load_row) * MAX_RESOURCES + int'(load_col));

    // Table addressing: the check and commit walk the requester's row, the
    // scan walks the row of the process under test.
    assign pidx    = sp_reg[PIDX-1:0];
    assign ridx    = sr_reg[RIDX-1:0];
    assign req_row = PIDX'(req_proc_reg);
    assign in_chk  = (state_reg == S_CHK_RD) || (state_reg == S_CHK_EV);
    assign in_com  = (state_reg == S_COM_RD) || (state_reg == S_COM_WR);
    assign row_sel = (in_chk || in_com) ? req_row : pidx;
    assign rd_addr = ADDR'(int'(row_sel) * MAX_RESOURCES + int'(ridx));

    assign sr_last = (RCNT'(sr_reg + RCNT'(1)) == cols);
    assign sp_last = (PCNT'(sp_reg + PCNT'(1)) == rows);

    // Shared datapath. During the scan and commit the requester's row is seen
    // with the pending request added, as the grant would leave it.
    assign pend_cur  = pend_reg[ridx];
    assign avail_cur = avail_reg[ridx];
    assign work_cur  = work_reg[ridx];
    assign use_pend  = !in_chk && (in_com || (32'(sp_reg) == 32'(req_proc_reg)));
    assign alloc_eff = use_pend ? amt_t'(alloc_rd_reg + pend_cur) : alloc_rd_reg;
    assign need_s    = $signed(CMP_BITS'(max_rd_reg)) - $signed(CMP_BITS'(alloc_eff));
    assign work_s    = $signed(CMP_BITS'(work_cur));
    assign pend_s    = $signed(CMP_BITS'(pend_cur));
    assign sum_w     = (WORK_BITS + 1)'(work_cur) + (WORK_BITS + 1)'(alloc_eff);
    assign work_sat  = sum_w[WORK_BITS] ? '1 : sum_w[WORK_BITS-1:0];

    assign chk_exceed = exceed_reg || (pend_s > need_s);
    assign chk_short  = short_reg || (pend_cur > avail_cur);

    // Moving on to the next process; at the end of a pass without progress
    // the state is unsafe.
    assign adv_prog = prog_reg || (state_reg == S_ADD_EV);
    always_comb
    begin
        adv_clear  = 1'b0;
        adv_unsafe = 1'b0;
        adv_sp     = PCNT'(sp_reg + PCNT'(1));
        adv_state  = S_PSEL;
        if (sp_last)
        begin
            adv_sp = '0;
            if (!adv_prog)
            begin
                adv_unsafe = 1'b1;
                adv_state  = S_OUT;
            end
            else
            begin
                adv_clear = 1'b1;
            end
        end
    end

    // Table write port: loads from the idle state, the grant during commit.
    assign alloc_we    = (accept && (cmd_item.cmd == bsa_pkg::CMD_ALLOC) && rin && pin)
                         || (state_reg == S_COM_WR);
    assign max_we      = accept && (cmd_item.cmd == bsa_pkg::CMD_MAX) && rin && pin;
    assign wr_addr     = (state_reg == S_COM_WR) ? rd_addr : load_addr;
    assign alloc_wdata = (state_reg == S_COM_WR) ? alloc_eff : amt_in;

    always_ff @(posedge clk)
    begin
        if (alloc_we)
            alloc_mem[wr_addr] <= alloc_wdata;
        if (max_we)
            max_mem[wr_addr] <= amt_in;
        alloc_rd_reg <= alloc_mem[rd_addr];
        max_rd_reg   <= max_mem[rd_addr];
    end

    // Sequencer and register next values.
    always_comb
    begin
        state_next     = state_reg;
        num_proc_next  = num_proc_reg;
        num_res_next   = num_res_reg;
        avail_next     = avail_reg;
        pend_next      = pend_reg;
        work_next      = work_reg;
        fin_next       = fin_reg;
        sp_next        = sp_reg;
        done_next      = done_reg;
        sr_next        = sr_reg;
        prog_next      = prog_reg;
        exceed_next    = exceed_reg;
        short_next     = short_reg;
        req_proc_next  = req_proc_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !verdict_ready;
        out_next       = out_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                bsa_pkg::CFG_NUM_PROCESSES:
                    num_proc_next = cfg_data[bsa_pkg::NUM_PROC_BITS-1:0];
                bsa_pkg::CFG_NUM_RESOURCES:
                    num_res_next = cfg_data[bsa_pkg::NUM_RES_BITS-1:0];
                default:
                    num_res_next = num_res_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd_item.cmd)
                        bsa_pkg::CMD_AVAIL:
                        begin
                            if (rin)
                                avail_next[load_col] = amt_in;
                        end
                        bsa_pkg::CMD_ALLOC, bsa_pkg::CMD_MAX:
                        begin
                            state_next = S_IDLE;
                        end
                        bsa_pkg::CMD_REQ:
                        begin
                            if (rin)
                                pend_next[load_col] = amt_in;
                            if (cmd_item.last)
                            begin
                                req_proc_next = cmd_item.process;
                                sr_next       = '0;
                                exceed_next   = 1'b0;
                                short_next    = 1'b0;
                                if (int'(cmd_item.process) >= int'(rows))
                                begin
                                    status_next = bsa_pkg::ST_CLAIM;
                                    state_next  = S_OUT;
                                end
                                else
                                begin
                                    state_next = S_CHK_RD;
                                end
                            end
                        end
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_CHK_RD:
                state_next = S_CHK_EV;
            S_CHK_EV:
            begin
                exceed_next = chk_exceed;
                short_next  = chk_short;
                if (!sr_last)
                begin
                    sr_next    = RCNT'(sr_reg + RCNT'(1));
                    state_next = S_CHK_RD;
                end
                else if (chk_exceed)
                begin
                    status_next = bsa_pkg::ST_CLAIM;
                    state_next  = S_OUT;
                end
                else if (chk_short)
                begin
                    status_next = bsa_pkg::ST_SHORT;
                    state_next  = S_OUT;
                end
                else
                begin
                    for (int i = 0; i < MAX_RESOURCES; i++)
                        work_next[i] = (i < int'(cols))
                                       ? WORK_BITS'(amt_t'(avail_reg[i] - pend_reg[i]))
                                       : '0;
                    fin_next   = '0;
                    sp_next    = '0;
                    sr_next    = '0;
                    done_next  = '0;
                    prog_next  = 1'b0;
                    state_next = S_PSEL;
                end
            end
            S_PSEL:
            begin
                if (fin_reg[pidx])
                begin
                    sp_next    = adv_sp;
                    state_next = adv_state;
                    if (adv_clear)
                        prog_next = 1'b0;
                    if (adv_unsafe)
                        status_next = bsa_pkg::ST_UNSAFE;
                end
                else
                begin
                    sr_next    = '0;
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
                state_next = S_SCAN_EV;
            S_SCAN_EV:
            begin
                if (need_s > work_s)
                begin
                    sp_next    = adv_sp;
                    state_next = adv_state;
                    if (adv_clear)
                        prog_next = 1'b0;
                    if (adv_unsafe)
                        status_next = bsa_pkg::ST_UNSAFE;
                end
                else if (sr_last)
                begin
                    sr_next    = '0;
                    state_next = S_ADD_RD;
                end
                else
                begin
                    sr_next    = RCNT'(sr_reg + RCNT'(1));
                    state_next = S_SCAN_RD;
                end
            end
            S_ADD_RD:
                state_next = S_ADD_EV;
            S_ADD_EV:
            begin
                work_next[ridx] = work_sat;
                if (!sr_last)
                begin
                    sr_next    = RCNT'(sr_reg + RCNT'(1));
                    state_next = S_ADD_RD;
                end
                else
                begin
                    fin_next[pidx] = 1'b1;
                    prog_next      = 1'b1;
                    done_next      = PCNT'(done_reg + PCNT'(1));
                    if (PCNT'(done_reg + PCNT'(1)) == rows)
                    begin
                        // Every process can finish: commit the grant.
                        sr_next    = '0;
                        state_next = S_COM_RD;
                    end
                    else
                    begin
                        sp_next    = adv_sp;
                        state_next = adv_state;
                        if (adv_clear)
                            prog_next = 1'b0;
                    end
                end
            end
            S_COM_RD:
                state_next = S_COM_WR;
            S_COM_WR:
            begin
                avail_next[ridx] = amt_t'(avail_cur - pend_cur);
                if (sr_last)
                begin
                    status_next = bsa_pkg::ST_GRANT;
                    state_next  = S_OUT;
                end
                else
                begin
                    sr_next    = RCNT'(sr_reg + RCNT'(1));
                    state_next = S_COM_RD;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || verdict_ready)
                begin
                    out_valid_next          = 1'b1;
                    out_next.status         = status_reg;
                    out_next.process_served = req_proc_reg;
                    for (int i = 0; i < MAX_RESOURCES; i++)
                        pend_next[i] = '0;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            num_proc_reg  <= bsa_pkg::NUM_PROC_BITS'(MAX_PROCESSES);
            num_res_reg   <= bsa_pkg::NUM_RES_BITS'(MAX_RESOURCES);
            for (int i = 0; i < MAX_RESOURCES; i++)
            begin
                avail_reg[i] <= '0;
                pend_reg[i]  <= '0;
                work_reg[i]  <= '0;
            end
            fin_reg       <= '0;
            sp_reg        <= '0;
            done_reg      <= '0;
            sr_reg        <= '0;
            prog_reg      <= 1'b0;
            exceed_reg    <= 1'b0;
            short_reg     <= 1'b0;
            req_proc_reg  <= '0;
            status_reg    <= bsa_pkg::ST_GRANT;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            num_proc_reg  <= num_proc_next;
            num_res_reg   <= num_res_next;
            avail_reg     <= avail_next;
            pend_reg      <= pend_next;
            work_reg      <= work_next;
            fin_reg       <= fin_next;
            sp_reg        <= sp_next;
            done_reg      <= done_next;
            sr_reg        <= sr_next;
            prog_reg      <= prog_next;
            exceed_reg    <= exceed_next;
            short_reg     <= short_next;
            req_proc_reg  <= req_proc_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    assign verdict_valid = out_valid_reg;
    assign verdict_item  = out_reg;

    // The process under test always lies inside the rows in use.
    a_scan_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN_RD || state_reg == S_PSEL) |-> (sp_reg < rows))
        else $error("scan process index outside the rows in use");

    // Table walks stay inside the columns in use.
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK_RD || state_reg == S_SCAN_RD || state_reg == S_ADD_RD
         || state_reg == S_COM_RD) |-> (sr_reg < cols))
        else $error("resource index outside the columns in use");

    // A commit starts only once every process in use has finished.
    a_commit_safe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COM_RD && $past(state_reg) == S_ADD_EV) |-> (done_reg == rows))
        else $error("commit entered before all processes finished");

    // A new verdict appears only out of the output state.
    a_verdict_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("verdict raised outside the output state");

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the banker's safety allocator.
`timescale 1ns / 1ps

module tb_top;

    localparam int ROWS          = bsa_pkg::MAX_PROCESSES_DEF;
    localparam int COLS          = bsa_pkg::MAX_RESOURCES_DEF;
    localparam int WORK_TOP      = (1 << (bsa_pkg::AMOUNT_BITS_DEF + 4)) - 1;
    // Several times the slowest legal run, dominated by the 16 x 8 scans.
    localparam int CYCLE_LIMIT   = 20000000;
    // Settling margin for trailing loads and non-final request elements.
    localparam int SETTLE_CYCLES = 16;

    logic                              clk;
    logic                              rst_n         = 1'b0;
    logic                              cmd_valid     = 1'b0;
    logic                              cmd_ready;
    bsa_pkg::item_t                    cmd_item      = '0;
    logic                              verdict_valid;
    logic                              verdict_ready = 1'b0;
    bsa_pkg::verdict_t                 verdict_item;
    logic                              cfg_valid     = 1'b0;
    logic                              cfg_ready;
    bsa_pkg::cfg_index_t               cfg_index     = bsa_pkg::CFG_NUM_PROCESSES;
    logic [bsa_pkg::CFG_DATA_BITS-1:0] cfg_data      = '0;

    // Shadow copy of the allocator state, updated as each item is accepted.
    bit [7:0] units_free [COLS];
    bit [7:0] held       [ROWS][COLS];
    bit [7:0] claim      [ROWS][COLS];
    bit [7:0] req_buf    [COLS];
    bit [4:0] cfg_rows = 5'd16;
    bit [3:0] cfg_cols = 4'd8;

    // Verdicts predicted for accepted final request elements, oldest first.
    bsa_pkg::verdict_t pending_verdicts [$];

    int mismatches  = 0;
    int items_sent  = 0;
    int cycle_count = 0;

    // Traffic shaping knobs shared between the test tasks and the driver processes.
    bit sender_gaps       = 1'b1;
    bit receiver_stalls   = 1'b1;
    int long_hold_cycles  = 0;
    bit hold_underway     = 1'b0;

    bankers_safety_allocator u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd_item      (cmd_item),
        .verdict_valid (verdict_valid),
        .verdict_ready (verdict_ready),
        .verdict_item  (verdict_item),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // A register value of zero acts as one, anything above the table size as the table size.
    function automatic int rows_in_use();
        if (cfg_rows == 0)
            return 1;
        if (cfg_rows > ROWS)
            return ROWS;
        return cfg_rows;
    endfunction

    function automatic int cols_in_use();
        if (cfg_cols == 0)
            return 1;
        if (cfg_cols > COLS)
            return COLS;
        return cfg_cols;
    endfunction

    function automatic bsa_pkg::item_t make_item(bsa_pkg::cmd_t c, int p, int r, int a, bit l);
        bsa_pkg::item_t it;
        it.cmd      = c;
        it.process  = p[3:0];
        it.resource = r[2:0];
        it.amount   = a[7:0];
        it.last     = l;
        return it;
    endfunction

    // Load values lean small so that grants stay reachable, with the full range now and then.
    function automatic int load_amount();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return $urandom_range(0, 7);
        if (pick < 85)
            return $urandom_range(0, 31);
        return $urandom_range(0, 255);
    endfunction

    // Works out the verdict for the buffered request of process p and commits a grant
    // into the shadow tables. Need is claim minus held, taken as a signed value.
    function automatic bsa_pkg::status_t decide_request(int p);
        int       n;
        int       m;
        int       done;
        bit       progress;
        bit       fits;
        bit [7:0] trial_free [COLS];
        bit [7:0] trial_held [ROWS][COLS];
        int       work       [COLS];
        bit       finished   [ROWS];
        n = rows_in_use();
        m = cols_in_use();
        if (p >= n)
            return bsa_pkg::ST_CLAIM;
        for (int r = 0; r < m; r++)
            if (int'(req_buf[r]) > int'(claim[p][r]) - int'(held[p][r]))
                return bsa_pkg::ST_CLAIM;
        for (int r = 0; r < m; r++)
            if (req_buf[r] > units_free[r])
                return bsa_pkg::ST_SHORT;

        trial_free = units_free;
        trial_held = held;
        for (int r = 0; r < m; r++)
        begin
            trial_free[r]    = trial_free[r] - req_buf[r];
            trial_held[p][r] = trial_held[p][r] + req_buf[r];
        end

        // Safety scan: keep finishing any process whose need fits in the work vector.
        // The verdict does not depend on the order in which processes are tried.
        for (int r = 0; r < COLS; r++)
            work[r] = (r < m) ? int'(trial_free[r]) : 0;
        finished = '{default: 1'b0};
        done     = 0;
        progress = 1'b1;
        while (done < n && progress)
        begin
            progress = 1'b0;
            for (int q = 0; q < n; q++)
            begin
                if (!finished[q])
                begin
                    fits = 1'b1;
                    for (int r = 0; r < m; r++)
                        if (int'(claim[q][r]) - int'(trial_held[q][r]) > work[r])
                            fits = 1'b0;
                    if (fits)
                    begin
                        // Work sums saturate at the top of the work width.
                        for (int r = 0; r < m; r++)
                        begin
                            work[r] = work[r] + int'(trial_held[q][r]);
                            if (work[r] > WORK_TOP)
                                work[r] = WORK_TOP;
                        end
                        finished[q] = 1'b1;
                        done++;
                        progress = 1'b1;
                    end
                end
            end
        end
        if (done < n)
            return bsa_pkg::ST_UNSAFE;

        units_free = trial_free;
        held       = trial_held;
        return bsa_pkg::ST_GRANT;
    endfunction

    // Applies one accepted item to the shadow state; a final request element yields a verdict.
    function automatic void apply_item(bsa_pkg::item_t it);
        bsa_pkg::verdict_t v;
        case (it.cmd)
            bsa_pkg::CMD_AVAIL: units_free[it.resource] = it.amount;
            bsa_pkg::CMD_ALLOC: held[it.process][it.resource] = it.amount;
            bsa_pkg::CMD_MAX:   claim[it.process][it.resource] = it.amount;
            bsa_pkg::CMD_REQ:
            begin
                req_buf[it.resource] = it.amount;
                if (it.last)
                begin
                    v.status         = decide_request(it.process);
                    v.process_served = it.process;
                    pending_verdicts.push_back(v);
                    // The request buffer is cleared whatever the verdict.
                    req_buf = '{default: 8'd0};
                end
            end
            default: ;
        endcase
    endfunction

    // Offers one item, optionally after a random idle burst, and holds it until accepted.
    task automatic send_item(input bsa_pkg::item_t it);
        if (sender_gaps && $urandom_range(0, 3) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_item  <= it;
        do @(posedge clk); while (!cmd_ready);
        apply_item(it);
        items_sent++;
    endtask

    // Lets every outstanding verdict come back, then leaves a settling margin for trailing loads.
    task automatic wait_idle();
        cmd_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes both size registers back to back while the block is idle.
    task automatic set_table_size(input logic [4:0] rows_data, input logic [4:0] cols_data);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= bsa_pkg::CFG_NUM_PROCESSES;
        cfg_data  <= rows_data;
        do @(posedge clk); while (!cfg_ready);
        cfg_rows = rows_data;
        cfg_index <= bsa_pkg::CFG_NUM_RESOURCES;
        cfg_data  <= cols_data;
        do @(posedge clk); while (!cfg_ready);
        cfg_cols = cols_data[3:0];
        cfg_valid <= 1'b0;
    endtask

    // Reloads the rows and columns in use with a small, mostly feasible state.
    task automatic refresh_tables();
        int n;
        int m;
        int h;
        n = rows_in_use();
        m = cols_in_use();
        for (int p = 0; p < n; p++)
            for (int r = 0; r < m; r++)
            begin
                h = $urandom_range(0, 3);
                send_item(make_item(bsa_pkg::CMD_ALLOC, p, r, h, 1'($urandom_range(0, 1))));
                send_item(make_item(bsa_pkg::CMD_MAX, p, r, h + $urandom_range(0, 4), 1'b0));
            end
        for (int r = 0; r < m; r++)
            send_item(make_item(bsa_pkg::CMD_AVAIL, 0, r, $urandom_range(0, 2 + n), 1'b0));
    endtask

    // A well-formed request: one element per column in use, in rotated order, last on the
    // final one. Amounts mostly fit both need and availability so the scan gets exercised.
    task automatic send_request(input int p);
        int m;
        int start;
        int r;
        int room;
        int pick;
        int amt;
        m     = cols_in_use();
        start = $urandom_range(0, m - 1);
        for (int k = 0; k < m; k++)
        begin
            r    = (start + k) % m;
            room = int'(claim[p][r]) - int'(held[p][r]);
            if (int'(units_free[r]) < room)
                room = int'(units_free[r]);
            if (room < 0)
                room = 0;
            pick = $urandom_range(0, 99);
            if (pick < 75)
                amt = $urandom_range(0, room);
            else if (pick < 90)
                amt = $urandom_range(0, room + 3);
            else
                amt = $urandom_range(0, 255);
            if (amt > 255)
                amt = 255;
            send_item(make_item(bsa_pkg::CMD_REQ, p, r, amt, k == m - 1));
        end
    endtask

    // One random phase at a given size: mostly complete requests, plus resource returns,
    // stray loads, occasional table refreshes and broken request fragments.
    task automatic run_mixed_phase(input logic [4:0] rows_data, input logic [4:0] cols_data,
                                   input int count);
        int n;
        int m;
        int start;
        int pick;
        int p;
        int r;
        int freed;
        set_table_size(rows_data, cols_data);
        refresh_tables();
        n     = rows_in_use();
        m     = cols_in_use();
        start = items_sent;
        while (items_sent - start < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                // A process hands back what it holds of one resource.
                p     = $urandom_range(0, n - 1);
                r     = $urandom_range(0, m - 1);
                freed = int'(held[p][r]) + int'(units_free[r]);
                if (freed > 255)
                    freed = 255;
                send_item(make_item(bsa_pkg::CMD_ALLOC, p, r, 0, 1'b0));
                send_item(make_item(bsa_pkg::CMD_AVAIL, 0, r, freed,
                                    1'($urandom_range(0, 1))));
            end
            else if (pick < 16)
                send_item(make_item(bsa_pkg::cmd_t'($urandom_range(0, 2)),
                                    $urandom_range(0, 15), $urandom_range(0, 7),
                                    load_amount(), 1'($urandom_range(0, 1))));
            else if (pick < 18 && n * m <= 16)
                refresh_tables();
            else if (pick < 28)
                send_item(make_item(bsa_pkg::CMD_REQ, $urandom_range(0, 15),
                                    $urandom_range(0, 7), $urandom_range(0, 255),
                                    $urandom_range(0, 3) == 0));
            else if ($urandom_range(0, 9) == 0)
                send_request($urandom_range(0, 15));
            else
                send_request($urandom_range(0, n - 1));
        end
    endtask

    // Every table entry is written once up front, so no later check reads an unwritten one.
    task automatic test_table_init();
        for (int p = 0; p < ROWS; p++)
            for (int r = 0; r < COLS; r++)
            begin
                send_item(make_item(bsa_pkg::CMD_ALLOC, p, r, (p + r) % 3, 1'b0));
                send_item(make_item(bsa_pkg::CMD_MAX, p, r, (p + r) % 3 + 2, 1'b0));
            end
        for (int r = 0; r < COLS; r++)
            send_item(make_item(bsa_pkg::CMD_AVAIL, 0, r, 4 + r, 1'b0));
    endtask

    // Hand-picked items at four processes and two resources; every need starts at two.
    task automatic test_special_cases();
        set_table_size(5'd4, 5'd2);
        // Last is ignored on loads.
        send_item(make_item(bsa_pkg::CMD_AVAIL, 0, 0, 6, 1'b1));
        send_item(make_item(bsa_pkg::CMD_AVAIL, 0, 1, 6, 1'b0));
        // Plain grant.
        send_item(make_item(bsa_pkg::CMD_REQ, 0, 0, 2, 1'b0));
        send_item(make_item(bsa_pkg::CMD_REQ, 0, 1, 1, 1'b1));
        // Beyond the maximum claim.
        send_item(make_item(bsa_pkg::CMD_REQ, 0, 0, 255, 1'b1));
        // A huge claim that can never be met makes any request that passes the checks unsafe.
        send_item(make_item(bsa_pkg::CMD_MAX, 1, 1, 255, 1'b0));
        send_item(make_item(bsa_pkg::CMD_REQ, 2, 0, 0, 1'b1));
        // Within the claim but more than is available.
        send_item(make_item(bsa_pkg::CMD_REQ, 1, 1, 100, 1'b1));
        send_item(make_item(bsa_pkg::CMD_MAX, 1, 1, 4, 1'b0));
        // Allocation above maximum gives a negative need: any request for it is over the
        // claim, while in the scan it never blocks.
        send_item(make_item(bsa_pkg::CMD_ALLOC, 3, 1, 255, 1'b0));
        send_item(make_item(bsa_pkg::CMD_REQ, 3, 1, 1, 1'b1));
        send_item(make_item(bsa_pkg::CMD_REQ, 2, 0, 1, 1'b1));
        // A process outside the rows in use.
        send_item(make_item(bsa_pkg::CMD_REQ, 15, 0, 0, 1'b1));
        // A buffered element beyond the columns in use is ignored by the check.
        send_item(make_item(bsa_pkg::CMD_REQ, 0, 7, 255, 1'b0));
        send_item(make_item(bsa_pkg::CMD_REQ, 0, 0, 0, 1'b1));
        send_item(make_item(bsa_pkg::CMD_ALLOC, 3, 1, 1, 1'b0));
        send_item(make_item(bsa_pkg::CMD_MAX, 15, 7, 8'hAA, 1'b1));
    endtask

    // The verdict side holds off for a long stretch while requests keep coming, so the
    // output register fills and the block has to stall its input.
    task automatic test_verdict_backpressure();
        sender_gaps      = 1'b0;
        long_hold_cycles = 300;
        while (!hold_underway)
            @(posedge clk);
        repeat (4) send_request($urandom_range(0, rows_in_use() - 1));
        sender_gaps = 1'b1;
    endtask

    // All sixteen processes hold the full amount of one resource, pushing the work sum
    // past its top during the scan.
    task automatic test_work_saturation();
        set_table_size(5'd16, 5'd1);
        send_item(make_item(bsa_pkg::CMD_AVAIL, 0, 0, 255, 1'b0));
        for (int p = 0; p < ROWS; p++)
            send_item(make_item(bsa_pkg::CMD_ALLOC, p, 0, 255, 1'b0));
        send_item(make_item(bsa_pkg::CMD_MAX, 0, 0, 255, 1'b0));
        send_item(make_item(bsa_pkg::CMD_REQ, 0, 0, 0, 1'b1));
    endtask

    // Sizes sweep the register extremes; most phases stay small to keep scans short.
    task automatic test_random_mix();
        run_mixed_phase(5'd2, 5'd1, 40);
        run_mixed_phase(5'd4, 5'd3, 70);
        run_mixed_phase(5'd0, 5'd0, 30);
        run_mixed_phase(5'd7, 5'd16, 40);
        run_mixed_phase(5'd1, 5'd8, 20);
        run_mixed_phase(5'd31, 5'd31, 30);
        run_mixed_phase(5'd5, 5'd4, 60);
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_steady_stream();
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        run_mixed_phase(5'd3, 5'd2, 60);
    endtask

    // Verdict ready: random stall bursts, or one long hold when a test asks for it.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold_cycles > 0)
            begin
                verdict_ready <= 1'b0;
                hold_underway = 1'b1;
                repeat (long_hold_cycles) @(posedge clk);
                long_hold_cycles = 0;
                hold_underway    = 1'b0;
            end
            else if (receiver_stalls && $urandom_range(0, 5) == 0)
            begin
                verdict_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            verdict_ready <= 1'b1;
        end
    end

    // Each accepted verdict is compared with the oldest prediction, field by field.
    always @(posedge clk)
    begin : verdict_check
        bsa_pkg::verdict_t want;
        if (rst_n && verdict_valid && verdict_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                mismatches++;
                $display("%0t: verdict with none expected: status %0d, process %0d",
                         $time, verdict_item.status, verdict_item.process_served);
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (verdict_item.status !== want.status)
                begin
                    mismatches++;
                    $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                             want.status, verdict_item.status);
                end
                if (verdict_item.process_served !== want.process_served)
                begin
                    mismatches++;
                    $display("%0t: process_served mismatch: expected %0d, actual %0d", $time,
                             want.process_served, verdict_item.process_served);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_init();
        test_special_cases();
        test_verdict_backpressure();
        test_work_saturation();
        test_random_mix();
        test_steady_stream();

        // Drain, then leave room for any stray verdict to show up.
        wait_idle();
        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
